[design/lattice_help_reconciliation_top_macros.svh]
// Assertion macros used by the checker file of the reconciliation block.
`ifndef LATTICE_HELP_RECONCILIATION_TOP_MACROS_SVH
`define LATTICE_HELP_RECONCILIATION_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LHR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lhr assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LHR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lhr assertion failed");

`endif

[design/lhr_pkg.sv]
// Types, constants and the per-coefficient datapath function of the reconciliation block.
package lhr_pkg;

  // Field widths.
  localparam int unsigned CoefW = 14;
  localparam int unsigned HintW = 2;

  // Modulus and derived widths.
  localparam int unsigned Q     = 12289;
  localparam int unsigned XW    = 18;  // 8*coef + 4*q holds below 2^18
  localparam int unsigned TW    = 4;   // floor(x/q) is at most 14
  localparam int unsigned CandW = 3;   // candidates are at most 7
  localparam int unsigned DistW = 14;  // each distance is at most q
  localparam int unsigned SumW  = 16;  // four distances sum to at most 4q
  localparam int unsigned TMax  = 14;

  localparam logic [XW-1:0]   DitherOff = XW'(4 * Q);
  localparam logic [XW-1:0]   TwoQ      = XW'(2 * Q);
  localparam logic [SumW-1:0] FlagThr   = SumW'(2 * Q);

  typedef logic [CoefW-1:0] coef_t;
  typedef logic [HintW-1:0] hint_t;

  // Both rounding candidates and the distance for one coefficient.
  typedef struct packed {
    logic [CandW-1:0] ca;
    logic [CandW-1:0] cb;
    logic [DistW-1:0] distance;
  } coef_res_t;

  // The quotient comes from parallel compares against the multiples of q.
  function automatic coef_res_t lhr_coef(input coef_t coef, input logic dither);
    logic [XW-1:0]  x;
    logic [TW-1:0]  t;
    logic [TW:0]    t_inc;
    logic [XW-1:0]  m;
    logic [XW-1:0]  diff;
    coef_res_t      res;
    x = {1'b0, coef, 3'b000} + (dither ? DitherOff : '0);
    t = '0;
    for (int k = 1; k <= TMax; k++) begin
      if (x >= XW'(k * Q)) begin
        t = TW'(k);
      end
    end
    t_inc        = {1'b0, t} + (TW+1)'(1);
    res.ca       = t_inc[CandW:1];
    res.cb       = t[TW-1:1];
    m            = XW'(res.ca) * TwoQ;
    diff         = (x >= m) ? (x - m) : (m - x);
    res.distance = diff[DistW-1:0];
    return res;
  endfunction

endpackage

[design/lattice_help_reconciliation_top.sv]
// Top level of the reconciliation hint generator for q = 12289.
//
// Usage: the input channel takes one group of four coefficients (positions
// j, j+256, j+512, j+768) and the dither bit of that group; the output
// channel returns the four 2-bit hints of the group. Both channels use a
// valid and stall handshake: an item moves on an edge where valid is high
// and stall is low.
// Path: an accepted item is registered in the input stage, passes the
// hint logic and lands in the result register once that register can
// advance, and is then offered on the output until it is taken.
// Throughput: one item per cycle while the output is not stalled; the
// per-coefficient quotient, distance sum and flag compare all fit
// between the input and result registers.
// Stalls: while the receiver stalls, the result register holds its item
// and the input stage can still take one more; the input is stalled only
// when both stages are full and the output is stalled.
// Reset: both stages are emptied and no item is offered.
module lattice_help_reconciliation_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lhr_pkg::coef_t coef_a_i,
  input  lhr_pkg::coef_t coef_b_i,
  input  lhr_pkg::coef_t coef_c_i,
  input  lhr_pkg::coef_t coef_d_i,
  input  logic          random_bit_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lhr_pkg::hint_t hint_a_o,
  output lhr_pkg::hint_t hint_b_o,
  output lhr_pkg::hint_t hint_c_o,
  output lhr_pkg::hint_t hint_d_o
);
  import lhr_pkg::*;

  logic      in_valid_q;
  coef_t     coef_q [4];
  logic      bit_q;
  logic      out_valid_q;
  hint_t     hint_a_q, hint_b_q, hint_c_q, hint_d_q;
  hint_t     hint_a_d, hint_b_d, hint_c_d, hint_d_d;
  logic      out_adv;
  logic      in_adv;
  coef_res_t res [4];
  logic [SumW-1:0]  dist_sum;
  logic             flag;
  logic [CandW-1:0] s [4];

  // Stage advance control.
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  // Input stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_adv) begin
      coef_q[0] <= coef_a_i;
      coef_q[1] <= coef_b_i;
      coef_q[2] <= coef_c_i;
      coef_q[3] <= coef_d_i;
      bit_q     <= random_bit_i;
    end
  end

  // Candidates and distances for each coefficient of the group.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res[i] = lhr_coef(coef_q[i], bit_q);
    end
  end

  // Distance sum, selection flag and the chosen candidates.
  always_comb begin
    dist_sum = SumW'(res[0].distance) + SumW'(res[1].distance)
             + SumW'(res[2].distance) + SumW'(res[3].distance);
    flag     = (dist_sum >= FlagThr);
    for (int i = 0; i < 4; i++) begin
      s[i] = flag ? res[i].cb : res[i].ca;
    end
  end

  // Hints a-c are differences mod 4 to s[3]; d is s[3] bit 0 and flag.
  always_comb begin
    hint_a_d = s[0][HintW-1:0] - s[3][HintW-1:0];
    hint_b_d = s[1][HintW-1:0] - s[3][HintW-1:0];
    hint_c_d = s[2][HintW-1:0] - s[3][HintW-1:0];
    hint_d_d = {s[3][0], flag};
  end

  // Result stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_q && out_adv) begin
      hint_a_q <= hint_a_d;
      hint_b_q <= hint_b_d;
      hint_c_q <= hint_c_d;
      hint_d_q <= hint_d_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hint_a_o    = hint_a_q;
  assign hint_b_o    = hint_b_q;
  assign hint_c_o    = hint_c_q;
  assign hint_d_o    = hint_d_q;

endmodule

[design/lhr_checker.sv]
// Port-level checker for the reconciliation block, with its bind statement.
`include "lattice_help_reconciliation_top_macros.svh"

module lhr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input lhr_pkg::hint_t hint_a_o,
  input lhr_pkg::hint_t hint_b_o,
  input lhr_pkg::hint_t hint_c_o,
  input lhr_pkg::hint_t hint_d_o
);
  import lhr_pkg::*;

  // A stalled result stays offered.
  `LHR_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its hints.
  `LHR_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable({hint_a_o, hint_b_o, hint_c_o, hint_d_o}))

  // The input is stalled only when a full result is held back.
  `LHR_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // An accepted item reaches the output if the output is not stalled when the item leaves the input stage.
  `LHR_ASSERT_NXT(a_latency, (in_valid_i && !in_stall_o) ##1 !out_stall_i, out_valid_o)

endmodule

bind lattice_help_reconciliation_top lhr_checker u_lhr_checker (.*);

[test/tb_lattice_help_reconciliation_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the reconciliation hint generator, with random idling and stalls.
module tb_lattice_help_reconciliation_top;

  localparam int unsigned MODULUS        = 12289;
  localparam int unsigned COEF_TOP       = 12288;
  localparam int unsigned COEF_MAX       = 16383;
  localparam int unsigned RANDOM_GROUPS  = 1100;
  localparam int unsigned GAP_PCT        = 9;
  localparam int unsigned CALM_FIRST     = 300;
  localparam int unsigned CALM_LAST      = 550;
  localparam int unsigned HOLD_AT        = 700;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 6;
  localparam int unsigned PRINT_CAP      = 100;

  // One group of four coefficients and its dither bit; slot 3 is position j.
  typedef struct packed {
    lhr_pkg::coef_t [3:0] coef;
    logic                 dither;
  } coef_group_t;

  typedef struct packed {
    lhr_pkg::hint_t a;
    lhr_pkg::hint_t b;
    lhr_pkg::hint_t c;
    lhr_pkg::hint_t d;
  } hint_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic           in_valid = 1'b0;
  logic           in_stall;
  lhr_pkg::coef_t coef_a = '0;
  lhr_pkg::coef_t coef_b = '0;
  lhr_pkg::coef_t coef_c = '0;
  lhr_pkg::coef_t coef_d = '0;
  logic           dither = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  lhr_pkg::hint_t hint_a;
  lhr_pkg::hint_t hint_b;
  lhr_pkg::hint_t hint_c;
  lhr_pkg::hint_t hint_d;

  coef_group_t pending_groups[$];
  hint_set_t   expected_hints[$];
  coef_group_t offered;
  hint_set_t   want;
  int unsigned groups_taken = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned quiet_cycles = 0;

  always #10 clk = ~clk;

  lattice_help_reconciliation_top uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .coef_a_i     (coef_a),
    .coef_b_i     (coef_b),
    .coef_c_i     (coef_c),
    .coef_d_i     (coef_d),
    .random_bit_i (dither),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .hint_a_o     (hint_a),
    .hint_b_o     (hint_b),
    .hint_c_o     (hint_c),
    .hint_d_o     (hint_d)
  );

  // Hints for one group: round each scaled coefficient both ways, sum the
  // distances for the upward choice and take the downward one if it is 2q or more.
  function automatic hint_set_t reconcile(coef_group_t g);
    int unsigned x, t, m, dist_sum, flag;
    int unsigned round_up[4], round_dn[4], pick[4];
    hint_set_t   h;
    dist_sum = 0;
    for (int i = 0; i < 4; i++) begin
      x = 8 * int'(g.coef[3 - i]) + 4 * MODULUS * int'(g.dither);
      t = x / MODULUS;
      round_up[i] = (t + 1) >> 1;
      round_dn[i] = t >> 1;
      m = round_up[i] * 2 * MODULUS;
      dist_sum += (x >= m) ? (x - m) : (m - x);
    end
    flag = (dist_sum >= 2 * MODULUS) ? 1 : 0;
    for (int i = 0; i < 4; i++) begin
      pick[i] = (flag != 0) ? round_dn[i] : round_up[i];
    end
    h.a = lhr_pkg::hint_t'((pick[0] - pick[3]) & 3);
    h.b = lhr_pkg::hint_t'((pick[1] - pick[3]) & 3);
    h.c = lhr_pkg::hint_t'((pick[2] - pick[3]) & 3);
    h.d = lhr_pkg::hint_t'((2 * pick[3] + flag) & 3);
    return h;
  endfunction

  // Random idle decision; no idling while the count sits in the calm window.
  function automatic bit gap_roll(int unsigned count);
    if (count >= CALM_FIRST && count < CALM_LAST) begin
      return 1'b0;
    end
    return ($urandom_range(0, 99) < GAP_PCT);
  endfunction

  // Coefficient draw: mostly in range, some anywhere in the field, some on a quotient edge.
  function automatic lhr_pkg::coef_t pick_coef();
    int unsigned roll, k, c;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      c = $urandom_range(0, COEF_TOP);
    end else if (roll < 82) begin
      c = $urandom_range(0, COEF_MAX);
    end else begin
      k = $urandom_range(1, 14);
      c = (k * MODULUS + 7) / 8 + $urandom_range(0, 2) - 1;
      if (c > COEF_MAX) begin
        c = COEF_MAX;
      end
    end
    return lhr_pkg::coef_t'(c);
  endfunction

  task automatic add_group(int unsigned a, int unsigned b, int unsigned c, int unsigned d,
                           bit dith);
    coef_group_t g;
    g.coef[0] = lhr_pkg::coef_t'(d);
    g.coef[1] = lhr_pkg::coef_t'(c);
    g.coef[2] = lhr_pkg::coef_t'(b);
    g.coef[3] = lhr_pkg::coef_t'(a);
    g.dither  = dith;
    pending_groups.push_back(g);
  endtask

  task automatic report_mismatch(string what, int unsigned exp_val, int unsigned got_val);
    errors++;
    // Keep the log short if the block is badly broken.
    if (errors <= PRINT_CAP) begin
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_val, got_val, $time);
    end
  endtask

  task automatic check_hint(string what, lhr_pkg::hint_t exp_val, lhr_pkg::hint_t got_val);
    if (got_val !== exp_val) begin
      report_mismatch(what, exp_val, got_val);
    end
  endtask

  // Sender: records each accepted group's hints and offers the next pending group.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_hints.push_back(reconcile(offered));
        groups_taken++;
      end
      if (pending_groups.size() > 0 && !gap_roll(groups_taken)) begin
        offered = pending_groups.pop_front();
        in_valid <= 1'b1;
        coef_a   <= offered.coef[3];
        coef_b   <= offered.coef[2];
        coef_c   <= offered.coef[1];
        coef_d   <= offered.coef[0];
        dither   <= offered.dither;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each accepted result against the oldest expectation,
  // stalls at random and once holds off long enough to fill the block.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hints.size() == 0) begin
          report_mismatch("result with nothing expected", 0, {hint_a, hint_b, hint_c, hint_d});
        end else begin
          want = expected_hints.pop_front();
          check_hint("hint_a", want.a, hint_a);
          check_hint("hint_b", want.b, hint_b);
          check_hint("hint_c", want.c, hint_c);
          check_hint("hint_d", want.d, hint_d);
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gap_roll(results_seen);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned big, rest, lo, hi, slot;
    int unsigned quad[4];

    // Extremes of the fields with both dither values.
    add_group(0, 0, 0, 0, 1'b0);
    add_group(0, 0, 0, 0, 1'b1);
    add_group(COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, 1'b0);
    add_group(COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, 1'b1);
    add_group(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
    add_group(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b1);
    add_group(0, COEF_TOP, COEF_MAX, 1, 1'b0);
    add_group(COEF_MAX, 0, 1, COEF_TOP, 1'b1);
    add_group('h2AAA, 'h1555, 'h2AAA, 'h1555, 1'b0);
    add_group('h1555, 'h2AAA, 'h1555, 'h2AAA, 1'b1);
    // Distance sum exactly at 2q selects the downward candidates; 8 below does not, 8 above does.
    add_group(1600, 1000, 600, 0, 1'b0);
    add_group(1600, 1000, 599, 0, 1'b0);
    add_group(0, 600, 1000, 1600, 1'b0);
    add_group(0, 601, 1000, 1600, 1'b0);
    // Quotient edges: 8*coef crossing q and 2q, and the top of the dither range.
    add_group(1536, 1537, 3072, 3073, 1'b0);
    add_group(1537, 1536, 3073, 3072, 1'b1);
    add_group(COEF_TOP - 1, 10752, 10753, 4609, 1'b1);
    // Coefficients at and above the modulus.
    add_group(12289, 14000, 15361, 15362, 1'b0);
    add_group(12289, 14000, 15361, 15362, 1'b1);

    for (int n = 0; n < RANDOM_GROUPS; n++) begin
      if ($urandom_range(0, 99) < 8) begin
        // One coefficient in the second rounding band balanced by three in the
        // first, so the distance sum lands on or next to 2q.
        big  = $urandom_range(1537, 3072);
        lo   = (big > 3072) ? big - 3072 : 0;
        hi   = (big < 1536) ? big : 1536;
        quad[1] = $urandom_range(lo, hi);
        rest = big - quad[1];
        lo   = (rest > 1536) ? rest - 1536 : 0;
        hi   = (rest < 1536) ? rest : 1536;
        quad[2] = $urandom_range(lo, hi);
        quad[3] = rest - quad[2] + $urandom_range(0, 2);
        quad[3] = (quad[3] == 0) ? 0 : quad[3] - 1;
        if (quad[3] > 1536) begin
          quad[3] = 1536;
        end
        quad[0] = big;
        slot = $urandom_range(0, 3);
        add_group(quad[slot], quad[(slot + 1) % 4], quad[(slot + 2) % 4],
                  quad[(slot + 3) % 4], 1'b0);
      end else begin
        add_group(pick_coef(), pick_coef(), pick_coef(), pick_coef(), $urandom_range(0, 1));
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_groups.size() > 0 || in_valid || expected_hints.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/lhr_pkg.sv
design/lattice_help_reconciliation_top.sv
design/lhr_checker.sv
test/tb_lattice_help_reconciliation_top.sv
